// ===== rtl/core/mlkm_pkg.sv =====
// ----------------------------------------------------------------------------
// mlkm_pkg
// Shared types, key codes and the keypad-to-pad remap for the modifier and
// layer key mapper.
// ----------------------------------------------------------------------------
package mlkm_pkg;

  // Field widths
  localparam int unsigned DevW    = 8;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned BankW   = 2;
  localparam int unsigned OctW    = 3;
  localparam int unsigned EffKeyW = 9;
  localparam int unsigned NumBanks = 4;

  // Stream data widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 40;

  // Special key codes
  localparam logic [KeyW-1:0] KeyTab    = 8'h09;
  localparam logic [KeyW-1:0] KeyShift  = 8'h10;
  localparam logic [KeyW-1:0] KeyCaps   = 8'h14;
  localparam logic [KeyW-1:0] KeyLShift = 8'hA0;
  localparam logic [KeyW-1:0] KeyRShift = 8'hA1;
  localparam logic [KeyW-1:0] KeyOne    = 8'h31;
  localparam logic [KeyW-1:0] KeyFive   = 8'h35;

  // Octave offset of key '3' (center)
  localparam logic [OctW-1:0] OctCenter = 3'd3;

  typedef logic signed [OctW-1:0] octave_t;
  typedef logic [BankW-1:0]       bank_t;

  // One result item
  typedef struct packed {
    logic                 state_changed;
    logic [EffKeyW-1:0]   effective_key;
    octave_t              octave;
    bank_t                active_bank;
    logic                 trigger;
    logic                 pressed;
    logic [KeyW-1:0]      raw_key;
    logic [DevW-1:0]      device_out;
  } result_t;

  // One input item
  typedef struct packed {
    logic            key_down;
    logic [KeyW-1:0] key_code;
    logic [DevW-1:0] device_id;
  } event_t;

  // Numeric keypad codes to pad codes 0x101..0x110, others pass through
  function automatic logic [EffKeyW-1:0] remap_pad(input logic [KeyW-1:0] code);
    logic [EffKeyW-1:0] res;
    res = {1'b0, code};
    case (code)
      8'h67:   res = 9'h101;
      8'h68:   res = 9'h102;
      8'h69:   res = 9'h103;
      8'h64:   res = 9'h104;
      8'h65:   res = 9'h105;
      8'h66:   res = 9'h106;
      8'h61:   res = 9'h107;
      8'h62:   res = 9'h108;
      8'h63:   res = 9'h109;
      8'h60:   res = 9'h10A;
      8'h6E:   res = 9'h10B;
      8'h0D:   res = 9'h10C;
      8'h6B:   res = 9'h10D;
      8'h6D:   res = 9'h10E;
      8'h6A:   res = 9'h10F;
      8'h6F:   res = 9'h110;
      default: res = {1'b0, code};
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/modifier_layer_key_mapper.sv =====
// ----------------------------------------------------------------------------
// modifier_layer_key_mapper
// Key event mapper: shift/caps/tab modifiers, four banks with octave offsets,
// optional keypad-to-pad remap.
// ----------------------------------------------------------------------------
// One key event per clock in and one result per event out, while the sink
// keeps up. An accepted event is held in the input register; once the output
// register is free or being emptied, the modifier and octave state is updated
// and the result lands in the output register in the same cycle. The
// sustained rate with a ready sink is one event per cycle, set by the
// read-modify-write of the modifier state, and the output register holds a
// result while the sink stalls. The input side keeps taking events while the
// input register is empty or the output register is free or being emptied.
// The numpad_mode register is written through the cfg channel, always ready.
module modifier_layer_key_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,     // numpad_mode
  // Event stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] device_id, [15:8] key_code, [16] key_down, [23:17] zero
  input  logic [mlkm_pkg::InDataW-1:0]   s_axis_tdata,
  // Result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] device_out, [15:8] raw_key, [16] pressed, [17] trigger,
  // [19:18] active_bank, [22:20] octave, [31:23] effective_key,
  // [32] state_changed, [39:33] zero
  output logic [mlkm_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned EvW  = $bits(mlkm_pkg::event_t);
  localparam int unsigned ResW = $bits(mlkm_pkg::result_t);

  logic                 numpad_q;
  logic                 shift_q, shift_d;
  logic                 caps_q, caps_d;
  logic                 tab_q, tab_d;
  mlkm_pkg::octave_t    oct_q [mlkm_pkg::NumBanks];
  mlkm_pkg::octave_t    oct_wr;
  logic                 oct_we;

  logic                 in_vld_q;
  mlkm_pkg::event_t     in_q;
  logic                 out_vld_q;
  mlkm_pkg::result_t    out_q, out_d;

  logic                 adv;
  logic                 take_in;
  logic                 is_shift, is_caps, is_tab, is_digit;
  mlkm_pkg::bank_t      bank_old, bank_new;

  // Handshake: stage advances when the output register is free or draining
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign take_in       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      numpad_q <= 1'b0;
    end else if (cfg_valid_i) begin
      numpad_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= mlkm_pkg::event_t'(s_axis_tdata[EvW-1:0]);
    end
  end

  // Event decode and state update
  always_comb begin
    is_shift = (in_q.key_code == mlkm_pkg::KeyShift) ||
               (in_q.key_code == mlkm_pkg::KeyLShift) ||
               (in_q.key_code == mlkm_pkg::KeyRShift);
    is_caps  = in_q.key_code == mlkm_pkg::KeyCaps;
    is_tab   = in_q.key_code == mlkm_pkg::KeyTab;
    is_digit = (in_q.key_code >= mlkm_pkg::KeyOne) &&
               (in_q.key_code <= mlkm_pkg::KeyFive);

    shift_d  = shift_q;
    caps_d   = caps_q;
    tab_d    = tab_q;
    bank_old = {caps_q, shift_q};
    oct_wr   = mlkm_pkg::octave_t'(in_q.key_code[2:0] - mlkm_pkg::OctCenter);
    oct_we   = 1'b0;

    out_d               = '0;
    out_d.device_out    = in_q.device_id;
    out_d.raw_key       = in_q.key_code;
    out_d.pressed       = in_q.key_down;

    if (is_shift) begin
      shift_d             = in_q.key_down;
      out_d.state_changed = shift_q != in_q.key_down;
    end else if (is_caps) begin
      if (in_q.key_down) begin
        caps_d              = !caps_q;
        out_d.state_changed = 1'b1;
      end
    end else if (is_tab) begin
      tab_d = in_q.key_down;
    end else if (tab_q) begin
      // Tab held: digit presses set the octave of the active bank
      if (in_q.key_down && is_digit) begin
        oct_we              = 1'b1;
        out_d.state_changed = oct_q[bank_old] != oct_wr;
      end
    end else begin
      out_d.trigger       = 1'b1;
      out_d.effective_key = numpad_q ? mlkm_pkg::remap_pad(in_q.key_code)
                                     : {1'b0, in_q.key_code};
    end

    bank_new          = {caps_d, shift_d};
    out_d.active_bank = bank_new;
    out_d.octave      = oct_we ? oct_wr : oct_q[bank_new];
  end

  // Modifier and octave state, updated as the result is registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
      tab_q   <= 1'b0;
      for (int i = 0; i < mlkm_pkg::NumBanks; i++) begin
        oct_q[i] <= '0;
      end
    end else if (in_vld_q && adv) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
      tab_q   <= tab_d;
      if (oct_we) begin
        oct_q[bank_old] <= oct_wr;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && adv) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(mlkm_pkg::OutDataW-ResW){1'b0}}, out_q};

  // Checks
  a_trig_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.trigger) |-> !out_q.state_changed)
    else $error("trigger result flags a state change");

  a_idle_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.trigger) |-> (out_q.effective_key == '0))
    else $error("non-trigger result carries a key");

  a_bank_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.active_bank == {caps_q, shift_q}))
    else $error("reported bank disagrees with modifier state");

  a_oct_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.octave == oct_q[{caps_q, shift_q}]))
    else $error("reported octave disagrees with bank state");

endmodule
